### hdl/sch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sch_pkg: shared types for the swept circle hit test
// Holds the control bundle that drives the shared squaring unit.
// ----------------------------------------------------------------------------
package sch_pkg;

  // Control for one operation of the shared squaring unit.
  typedef struct packed {
    logic en;   // load a new result this cycle
    logic acc;  // add the new square to the held result instead of replacing it
  } sq_ctl_t;

endpackage : sch_pkg
`default_nettype wire

### hdl/sch_sq_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sch_sq_unit: shared square and accumulate unit
// Squares one unsigned operand per cycle and registers the result, either
// replacing the held value or adding to it.
// ----------------------------------------------------------------------------
module sch_sq_unit
  import sch_pkg::*;
#(
  parameter int OP_BITS = 13
) (
  input  wire logic                 clk,
  input  wire sq_ctl_t              ctl,
  input  wire logic [OP_BITS-1:0]   op,
  output logic      [2*OP_BITS:0]   res
);

  logic [2*OP_BITS-1:0] prod;
  logic [2*OP_BITS:0]   res_r;
  logic [2*OP_BITS:0]   res_nxt;

  assign prod = op * op;

  always_comb begin
    res_nxt = res_r;
    if (ctl.en) begin
      if (ctl.acc) begin
        res_nxt = res_r + (2*OP_BITS+1)'(prod);
      end else begin
        res_nxt = (2*OP_BITS+1)'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule : sch_sq_unit
`default_nettype wire

### hdl/swept_circle_hit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swept_circle_hit_test: swept circle collision along a Bresenham line
// Walks the pixel line from the mover's start to its end and reports whether
// the moving circle touches the stationary circle at any visited pixel.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns exactly one hit flag per
// item. After the input transfer a setup state prepares the walk (deltas,
// major axis, error term, and the squared radius sum), then the block visits
// pixels in order from the start point. A pixel whose x or y offset alone
// exceeds the radius sum skips the squaring states; any other pixel has its
// two squares go through one shared squaring unit one after the other.
// The walk stops at the first touching pixel or after the end pixel. A done
// state then moves the flag into the output register once that register is
// empty or being read. in_ready is high only while the block is idle; a
// finished result may still wait in the output register while the next
// item is taken in.
// A distance exactly equal to the radius sum counts as a hit.
// ----------------------------------------------------------------------------
module swept_circle_hit_test
  import sch_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_BITS-1:0]  in_target_x,
  input  wire logic signed [COORD_BITS-1:0]  in_target_y,
  input  wire logic        [RADIUS_BITS-1:0] in_target_radius,
  input  wire logic signed [COORD_BITS-1:0]  in_start_x,
  input  wire logic signed [COORD_BITS-1:0]  in_start_y,
  input  wire logic signed [COORD_BITS-1:0]  in_end_x,
  input  wire logic signed [COORD_BITS-1:0]  in_end_y,
  input  wire logic        [RADIUS_BITS-1:0] in_mover_radius,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit
);

  // Radius sum and the squared-offset operands share one width.
  localparam int OPW = RADIUS_BITS + 1;
  // Width wide enough for both an absolute coordinate offset and the radius sum.
  localparam int DW  = (COORD_BITS + 1 > OPW) ? COORD_BITS + 1 : OPW;
  localparam int SQW = 2 * OPW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_SQX   = 3'd3;
  localparam logic [2:0] S_SQY   = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Item and walk registers.
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [COORD_BITS-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [OPW-1:0]               rsum_r, rsum_nxt;
  logic [COORD_BITS-1:0]        major_r, major_nxt, minor_r, minor_nxt;
  logic [COORD_BITS-1:0]        remain_r, remain_nxt;
  logic [COORD_BITS:0]          err_r, err_nxt;
  logic                         x_major_r, x_major_nxt;
  logic                         negx_r, negx_nxt, negy_r, negy_nxt;
  logic [OPW-1:0]               ax_r, ax_nxt, ay_r, ay_nxt;
  logic                         far_r, far_nxt;
  logic [2*OPW-1:0]             rsq_r, rsq_nxt;
  logic                         rsq_load_r, rsq_load_nxt;
  logic                         hit_r, hit_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;

  // Shared squaring unit.
  sq_ctl_t        sq_ctl;
  logic [OPW-1:0] sq_op;
  logic [SQW-1:0] sq_res;

  sch_sq_unit #(
    .OP_BITS (OPW)
  ) u_sq (
    .clk (clk),
    .ctl (sq_ctl),
    .op  (sq_op),
    .res (sq_res)
  );

  // Setup arithmetic: line deltas and their magnitudes.
  logic signed [COORD_BITS:0] ddx, ddy;
  logic        [COORD_BITS:0] ddx_abs, ddy_abs;
  logic        [COORD_BITS-1:0] adx, ady;

  assign ddx     = ({ex_r[COORD_BITS-1], ex_r} - {x_r[COORD_BITS-1], x_r});
  assign ddy     = ({ey_r[COORD_BITS-1], ey_r} - {y_r[COORD_BITS-1], y_r});
  assign ddx_abs = ddx[COORD_BITS] ? (COORD_BITS+1)'(-ddx) : ddx;
  assign ddy_abs = ddy[COORD_BITS] ? (COORD_BITS+1)'(-ddy) : ddy;
  assign adx     = ddx_abs[COORD_BITS-1:0];
  assign ady     = ddy_abs[COORD_BITS-1:0];

  // Per-pixel offsets from the stationary centre.
  logic signed [COORD_BITS:0] ofx, ofy;
  logic        [COORD_BITS:0] ofx_abs, ofy_abs;
  logic        [DW-1:0]       ofx_w, ofy_w, rsum_w;

  assign ofx     = {x_r[COORD_BITS-1], x_r} - {cx_r[COORD_BITS-1], cx_r};
  assign ofy     = {y_r[COORD_BITS-1], y_r} - {cy_r[COORD_BITS-1], cy_r};
  assign ofx_abs = ofx[COORD_BITS] ? (COORD_BITS+1)'(-ofx) : ofx;
  assign ofy_abs = ofy[COORD_BITS] ? (COORD_BITS+1)'(-ofy) : ofy;
  assign ofx_w   = DW'(ofx_abs);
  assign ofy_w   = DW'(ofy_abs);
  assign rsum_w  = DW'(rsum_r);

  // Bresenham error update.
  logic [COORD_BITS:0] err_sum;
  logic [COORD_BITS:0] major_w;
  logic                near_hit;

  assign err_sum  = err_r + (COORD_BITS+1)'(minor_r);
  assign major_w  = (COORD_BITS+1)'(major_r);
  assign near_hit = !far_r && (sq_res <= SQW'(rsq_r));

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    rsum_nxt      = rsum_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    remain_nxt    = remain_r;
    err_nxt       = err_r;
    x_major_nxt   = x_major_r;
    negx_nxt      = negx_r;
    negy_nxt      = negy_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    far_nxt       = far_r;
    rsq_nxt       = rsq_r;
    rsq_load_nxt  = 1'b0;
    hit_nxt       = hit_r;
    out_hit_nxt   = out_hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sq_ctl.en     = 1'b0;
    sq_ctl.acc    = 1'b0;
    sq_op         = rsum_r;

    // The squared radius sum lands in the unit's register in the cycle after setup.
    if (rsq_load_r) begin
      rsq_nxt = sq_res[2*OPW-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cx_nxt    = in_target_x;
          cy_nxt    = in_target_y;
          x_nxt     = in_start_x;
          y_nxt     = in_start_y;
          ex_nxt    = in_end_x;
          ey_nxt    = in_end_y;
          rsum_nxt  = OPW'(in_target_radius) + OPW'(in_mover_radius);
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        negx_nxt     = ddx[COORD_BITS];
        negy_nxt     = ddy[COORD_BITS];
        x_major_nxt  = (adx >= ady);
        major_nxt    = (adx >= ady) ? adx : ady;
        minor_nxt    = (adx >= ady) ? ady : adx;
        remain_nxt   = (adx >= ady) ? adx : ady;
        err_nxt      = (COORD_BITS+1)'(((adx >= ady) ? adx : ady) >> 1);
        sq_ctl.en    = 1'b1;
        sq_op        = rsum_r;
        rsq_load_nxt = 1'b1;
        state_nxt    = S_DIFF;
      end
      S_DIFF: begin
        far_nxt = (ofx_w > rsum_w) || (ofy_w > rsum_w);
        ax_nxt  = ofx_w[OPW-1:0];
        ay_nxt  = ofy_w[OPW-1:0];
        if ((ofx_w > rsum_w) || (ofy_w > rsum_w)) begin
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        sq_ctl.en = 1'b1;
        sq_op     = ax_r;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sq_ctl.en  = 1'b1;
        sq_ctl.acc = 1'b1;
        sq_op      = ay_r;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        if (near_hit) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (remain_r == '0) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          // Minor axis steps when the error term reaches the major delta.
          if (err_sum >= major_w) begin
            err_nxt = err_sum - major_w;
            if (x_major_r) begin
              y_nxt = negy_r ? y_r - COORD_BITS'(1) : y_r + COORD_BITS'(1);
            end else begin
              x_nxt = negx_r ? x_r - COORD_BITS'(1) : x_r + COORD_BITS'(1);
            end
          end else begin
            err_nxt = err_sum;
          end
          if (x_major_r) begin
            x_nxt = negx_r ? x_r - COORD_BITS'(1) : x_r + COORD_BITS'(1);
          end else begin
            y_nxt = negy_r ? y_r - COORD_BITS'(1) : y_r + COORD_BITS'(1);
          end
          remain_nxt = remain_r - COORD_BITS'(1);
          state_nxt  = S_DIFF;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rsq_load_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rsq_load_r  <= rsq_load_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    rsum_r    <= rsum_nxt;
    major_r   <= major_nxt;
    minor_r   <= minor_nxt;
    remain_r  <= remain_nxt;
    err_r     <= err_nxt;
    x_major_r <= x_major_nxt;
    negx_r    <= negx_nxt;
    negy_r    <= negy_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    far_r     <= far_nxt;
    rsq_r     <= rsq_nxt;
    hit_r     <= hit_nxt;
    out_hit_r <= out_hit_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule : swept_circle_hit_test
`default_nettype wire
